// ===== src/md5pw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5pw_pkg: shared types and functions for the address-to-password deriver
// Holds the MD5 round constants, the round function and the message
// builders for the two hash passes.
// ----------------------------------------------------------------------------
package md5pw_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } state_type;

   localparam state_type MD5_IV = '{a: 32'h67452301, b: 32'hefcdab89,
                                    c: 32'h98badcfe, d: 32'h10325476};

   localparam int NUM_ROUNDS = 64;
   localparam int FIXED_LEN = 38;
   localparam logic [FIXED_LEN*8-1:0] FIXED_TEXT = "555043444541554C5450415353504852415345";
   localparam logic [6:0] LETTER_BASE = 7'h41;
   localparam logic [4:0] LETTER_COUNT = 5'd26;
   // 2521 / 2^16 is close enough to 1/26 for sums up to 510.
   localparam logic [11:0] RECIP_26 = 12'd2521;

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROUND_SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                       4, 11, 16, 23, 6, 10, 15, 21};

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
   endfunction

   function automatic block_type pack_block(input logic [7:0] blk [64]);
      block_type w;
      for (int i = 0; i < 16; i++) begin
         w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      end
      return w;
   endfunction

   // First pass: 12 hex characters of the address, the fixed text, a zero byte.
   function automatic block_type msg_first(input logic [47:0] addr);
      logic [7:0] blk [64];
      for (int i = 0; i < 64; i++) begin
         blk[i] = 8'h00;
      end
      for (int i = 0; i < 12; i++) begin
         blk[i] = hex_char(addr[44-4*i +: 4]);
      end
      for (int j = 0; j < FIXED_LEN; j++) begin
         blk[12+j] = FIXED_TEXT[(FIXED_LEN-1-j)*8 +: 8];
      end
      blk[51] = 8'h80;
      blk[56] = 8'h98;
      blk[57] = 8'h01;
      return pack_block(blk);
   endfunction

   // Second pass: six pairs of '0' and a hex digit, then a zero byte.
   function automatic block_type msg_second(input logic [23:0] nib);
      logic [7:0] blk [64];
      for (int i = 0; i < 64; i++) begin
         blk[i] = 8'h00;
      end
      for (int i = 0; i < 6; i++) begin
         blk[2*i] = 8'h30;
         blk[2*i+1] = hex_char(nib[4*i +: 4]);
      end
      blk[13] = 8'h80;
      blk[56] = 8'h68;
      return pack_block(blk);
   endfunction

   function automatic state_type md5_round(input state_type s, input block_type w,
                                           input int i);
      word_type f;
      word_type t;
      word_type r;
      int g;
      int sh;
      case (i >> 4)
         0: begin
            f = (s.b & s.c) | (~s.b & s.d);
            g = i;
         end
         1: begin
            f = (s.d & s.b) | (~s.d & s.c);
            g = (5*i + 1) & 15;
         end
         2: begin
            f = s.b ^ s.c ^ s.d;
            g = (3*i + 5) & 15;
         end
         default: begin
            f = s.c ^ (s.b | ~s.d);
            g = (7*i) & 15;
         end
      endcase
      sh = ROUND_SHIFT[((i >> 4) << 2) | (i & 3)];
      t = s.a + f + ROUND_K[i] + w[g];
      r = (t << sh) | (t >> (32 - sh));
      return '{a: s.d, b: s.b + r, c: s.b, d: s.c};
   endfunction

   function automatic logic [6:0] letter(input logic [8:0] s);
      logic [20:0] p;
      logic [4:0] q;
      logic [8:0] r;
      p = {12'h000, s} * {9'h000, RECIP_26};
      q = p[20:16];
      r = s - ({4'h0, q} * {4'h0, LETTER_COUNT});
      return LETTER_BASE + {2'b00, r[4:0]};
   endfunction

endpackage

// ===== src/md5pw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5pw_if: request and response channels of the password deriver
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface md5pw_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] hw_address;
   modport source(output valid, output hw_address, input ready);
   modport sink(input valid, input hw_address, output ready);
endinterface

interface md5pw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char0;
   logic [6:0] char1;
   logic [6:0] char2;
   logic [6:0] char3;
   logic [6:0] char4;
   logic [6:0] char5;
   logic [6:0] char6;
   logic [6:0] char7;
   modport source(output valid, output char0, output char1, output char2, output char3,
                  output char4, output char5, output char6, output char7, input ready);
   modport sink(input valid, input char0, input char1, input char2, input char3,
                input char4, input char5, input char6, input char7, output ready);
endinterface

// ===== src/mac_to_password_md5_derive_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_to_password_md5_derive_core: password from a hardware address
// Two fully unrolled MD5 compressions, one round per register stage.
// ----------------------------------------------------------------------------
// The path has 132 register stages, 128 round stages plus four others.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset: synchronous, clears only the valid bits of every stage.
module mac_to_password_md5_derive_core (
   input logic         clock,
   input logic         reset,
   md5pw_req_if.sink   req,
   md5pw_rsp_if.source rsp
);
   import md5pw_pkg::*;

   localparam int R = NUM_ROUNDS;

   logic        adv_in;
   state_type   st1_ff [R+1];
   logic [47:0] addr_ff [R+1];
   logic        v1_ff [R+1];
   state_type   st2_ff [R+1];
   logic [23:0] nib_ff [R+1];
   logic        v2_ff [R+1];
   state_type   dig_ff;
   logic        dig_v_ff;
   logic [6:0]  char_ff [8];
   logic        out_v_ff;
   state_type   sum1_in;

   assign adv_in = rsp.ready || !out_v_ff;
   assign req.ready = adv_in;
   assign sum1_in = '{a: st1_ff[R].a + MD5_IV.a, b: st1_ff[R].b + MD5_IV.b,
                      c: st1_ff[R].c + MD5_IV.c, d: st1_ff[R].d + MD5_IV.d};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= R; k++) begin
            v1_ff[k] <= 1'b0;
            v2_ff[k] <= 1'b0;
         end
         dig_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv_in) begin
         v1_ff[0] <= req.valid;
         for (int k = 0; k < R; k++) begin
            v1_ff[k+1] <= v1_ff[k];
            v2_ff[k+1] <= v2_ff[k];
         end
         v2_ff[0] <= v1_ff[R];
         dig_v_ff <= v2_ff[R];
         out_v_ff <= dig_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         st1_ff[0] <= MD5_IV;
         addr_ff[0] <= req.hw_address;
         for (int k = 0; k < R; k++) begin
            st1_ff[k+1] <= md5_round(st1_ff[k], msg_first(addr_ff[k]), k);
            addr_ff[k+1] <= addr_ff[k];
         end
         // Low nibbles of digest bytes 0..5: four from word a, two from word b.
         st2_ff[0] <= MD5_IV;
         nib_ff[0] <= {sum1_in.b[11:8], sum1_in.b[3:0], sum1_in.a[27:24],
                       sum1_in.a[19:16], sum1_in.a[11:8], sum1_in.a[3:0]};
         for (int k = 0; k < R; k++) begin
            st2_ff[k+1] <= md5_round(st2_ff[k], msg_second(nib_ff[k]), k);
            nib_ff[k+1] <= nib_ff[k];
         end
         dig_ff <= '{a: st2_ff[R].a + MD5_IV.a, b: st2_ff[R].b + MD5_IV.b,
                     c: st2_ff[R].c + MD5_IV.c, d: st2_ff[R].d + MD5_IV.d};
         // Byte i pairs with byte i+8: word a with c, word b with d.
         for (int i = 0; i < 4; i++) begin
            char_ff[i] <= letter({1'b0, dig_ff.a[8*i +: 8]} + {1'b0, dig_ff.c[8*i +: 8]});
            char_ff[i+4] <= letter({1'b0, dig_ff.b[8*i +: 8]} + {1'b0, dig_ff.d[8*i +: 8]});
         end
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.char0 = char_ff[0];
   assign rsp.char1 = char_ff[1];
   assign rsp.char2 = char_ff[2];
   assign rsp.char3 = char_ff[3];
   assign rsp.char4 = char_ff[4];
   assign rsp.char5 = char_ff[5];
   assign rsp.char6 = char_ff[6];
   assign rsp.char7 = char_ff[7];

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input taken while the pipeline is stalled");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.char0 >= 7'd65 && rsp.char0 <= 7'd90
                     && rsp.char7 >= 7'd65 && rsp.char7 <= 7'd90))
      else $error("password character outside A..Z");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      !adv_in |=> (v2_ff[0] == $past(v2_ff[0]) && dig_v_ff == $past(dig_v_ff)))
      else $error("pipeline moved during a stall");

endmodule
